/* rtl/core/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern scan unit.
// No dependencies; used by every module in rtl/core.
package wbps_pkg;

  localparam int unsigned PatternMax = 32;
  localparam int unsigned WinDepth   = PatternMax - 1;
  localparam int unsigned LenW       = 6;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned DataW      = 64;
  localparam int unsigned IndexW     = 3;

  typedef enum logic [IndexW-1:0] {
    REG_PAT0,
    REG_PAT1,
    REG_PAT2,
    REG_PAT3,
    REG_MASK,
    REG_LEN,
    REG_BASE
  } cfg_reg_e;

  // Compare setting for one window position, already aligned to byte age.
  typedef struct packed {
    logic       en;
    logic [7:0] want;
  } age_cmp_t;

  typedef struct packed {
    age_cmp_t [PatternMax-1:0] age;
    logic [LenW-1:0]           len;
    logic [AddrW-1:0]          adj;
  } scan_cfg_t;

endpackage

/* rtl/core/wbps_cell.sv */
// One window cell: holds a byte of history and compares it to its aligned signature byte.
// Depends on wbps_pkg.
module wbps_cell (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic [7:0]          byte_i,
  input  wbps_pkg::age_cmp_t  cmp_i,
  output logic [7:0]          byte_o,
  output logic                ok_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // The cell compares the byte it will pass on, which is one age older than its input.
  assign ok_o   = !cmp_i.en || (byte_q == cmp_i.want);

endmodule

/* rtl/core/wbps_cfg.sv */
// Configuration registers and the derived per-age compare settings for the scan unit.
// Depends on wbps_pkg.
module wbps_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [wbps_pkg::IndexW-1:0]       cfg_index_i,
  input  logic [wbps_pkg::DataW-1:0]        cfg_data_i,
  output wbps_pkg::scan_cfg_t               scan_cfg_o,
  output logic                              busy_o
);

  logic [wbps_pkg::PatternMax*8-1:0] pat_q;
  logic [wbps_pkg::PatternMax-1:0]   mask_q;
  logic [wbps_pkg::LenW-1:0]         len_q;
  logic [wbps_pkg::AddrW-1:0]        base_q;
  wbps_pkg::scan_cfg_t               scan_cfg_d, scan_cfg_q;
  logic                              busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      mask_q <= '0;
      len_q  <= '0;
      base_q <= '0;
      busy_q <= 1'b1;
    end else begin
      busy_q <= cfg_valid_i;
      if (cfg_valid_i) begin
        case (wbps_pkg::cfg_reg_e'(cfg_index_i))
          wbps_pkg::REG_PAT0: pat_q[0*64 +: 64]  <= cfg_data_i;
          wbps_pkg::REG_PAT1: pat_q[1*64 +: 64]  <= cfg_data_i;
          wbps_pkg::REG_PAT2: pat_q[2*64 +: 64]  <= cfg_data_i;
          wbps_pkg::REG_PAT3: pat_q[3*64 +: 64]  <= cfg_data_i;
          wbps_pkg::REG_MASK: mask_q <= cfg_data_i[wbps_pkg::PatternMax-1:0];
          wbps_pkg::REG_LEN:  len_q  <= cfg_data_i[wbps_pkg::LenW-1:0];
          wbps_pkg::REG_BASE: base_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Signature byte k faces the byte of age len-1-k, so the settings are reversed
  // against the length here once, off the byte path.
  always_comb begin
    logic [wbps_pkg::LenW-1:0] len_sat;
    logic [wbps_pkg::LenW-1:0] k;
    logic [wbps_pkg::LenW-1:0] len_m1;
    len_sat = (len_q > wbps_pkg::LenW'(wbps_pkg::PatternMax))
              ? wbps_pkg::LenW'(wbps_pkg::PatternMax) : len_q;
    scan_cfg_d.len = len_sat;
    for (int a = 0; a < wbps_pkg::PatternMax; a++) begin
      k = len_sat - wbps_pkg::LenW'(1) - wbps_pkg::LenW'(a);
      scan_cfg_d.age[a].en   = (wbps_pkg::LenW'(a) < len_sat) && mask_q[k[4:0]];
      scan_cfg_d.age[a].want = pat_q[k[4:0]*8 +: 8];
    end
    len_m1 = (len_sat == '0) ? '0 : len_sat - wbps_pkg::LenW'(1);
    scan_cfg_d.adj = base_q - wbps_pkg::AddrW'(len_m1);
  end

  always_ff @(posedge clk_i) begin
    scan_cfg_q <= scan_cfg_d;
  end

  assign scan_cfg_o = scan_cfg_q;
  assign busy_o     = busy_q;

endmodule

/* rtl/core/wildcard_byte_pattern_scan_unit.sv */
// Top level of the wildcard byte pattern scan unit: window cell chain, scan control, result register.
// Depends on wbps_pkg, wbps_cell and wbps_cfg.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   in       | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//   out      | out_valid_o/ out_ready_i| found_o, match_address_o
//   cfg      | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while in_ready_o is high; its result, if any, shows at the output register
// the next cycle, and a new byte is taken while that result waits if out_ready_i is high.
// After reset and after each configuration write, in_ready_o is low
// while the aligned compare settings reload.
// A held result stalls input only when the output register cannot drain.
module wildcard_byte_pattern_scan_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [wbps_pkg::AddrW-1:0]   match_address_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wbps_pkg::IndexW-1:0]  cfg_index_i,
  input  logic [wbps_pkg::DataW-1:0]   cfg_data_i
);

  wbps_pkg::scan_cfg_t              scan_cfg;
  logic                             cfg_busy;
  logic [7:0]                       win [wbps_pkg::WinDepth];
  logic [wbps_pkg::WinDepth-1:0]    cell_ok;
  logic                             accept;
  logic                             age0_ok;
  logic                             hit;
  logic                             emit_found;
  logic                             emit_none;
  logic [wbps_pkg::LenW-1:0]        seen_q, seen_inc;
  logic [wbps_pkg::AddrW-1:0]       idx_q;
  logic                             reported_q;
  logic                             out_valid_q;
  logic                             found_q;
  logic [wbps_pkg::AddrW-1:0]       addr_q;

  assign cfg_ready_o = 1'b1;

  wbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .scan_cfg_o  (scan_cfg),
    .busy_o      (cfg_busy)
  );

  assign in_ready_o = !cfg_busy && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Cell i holds the byte of age i+1 and checks it against its aligned setting.
  for (genvar i = 0; i < wbps_pkg::WinDepth; i++) begin : g_cell
    logic [7:0] cell_in;
    if (i == 0) begin : g_head
      assign cell_in = data_byte_i;
    end else begin : g_body
      assign cell_in = win[i-1];
    end
    wbps_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (accept),
      .byte_i  (cell_in),
      .cmp_i   (scan_cfg.age[i+1]),
      .byte_o  (win[i]),
      .ok_o    (cell_ok[i])
    );
  end

  assign age0_ok  = !scan_cfg.age[0].en || (data_byte_i == scan_cfg.age[0].want);
  assign seen_inc = (seen_q == wbps_pkg::LenW'(wbps_pkg::PatternMax))
                    ? seen_q : seen_q + wbps_pkg::LenW'(1);
  assign hit        = age0_ok && (&cell_ok) && (seen_inc >= scan_cfg.len);
  assign emit_found = !reported_q && hit;
  assign emit_none  = !reported_q && !hit && last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      idx_q       <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte_i) begin
          seen_q     <= '0;
          idx_q      <= '0;
          reported_q <= 1'b0;
        end else begin
          seen_q     <= seen_inc;
          // The byte index stops one short of all ones and holds there, so it never
          // wraps back to zero.
          idx_q      <= (&idx_q[wbps_pkg::AddrW-1:1]) ? idx_q
                                                      : idx_q + wbps_pkg::AddrW'(1);
          reported_q <= reported_q || emit_found;
        end
      end
      if (accept && (emit_found || emit_none)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The first matching byte sits len-1 bytes before the current one; adj folds that in.
  always_ff @(posedge clk_i) begin
    if (accept && (emit_found || emit_none)) begin
      found_q <= emit_found;
      addr_q  <= emit_found ? scan_cfg.adj + idx_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

endmodule
